>>> rtl/ptzfb_pkg.sv
// Shared types and constants for the PTZ command frame builder.
package ptzfb_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CMD_W    = 5;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned DIR_W    = 3;
    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned IDX_W    = $clog2(FRAME_LEN);

    localparam logic [BYTE_W-1:0]  FRAME_SYNC   = 8'hFF;
    localparam logic [BYTE_W-1:0]  STRAY_MASK   = 8'hE1;
    localparam logic [BYTE_W-1:0]  CAM_ON_C1    = 8'h88;
    localparam logic [BYTE_W-1:0]  CAM_OFF_C1   = 8'h08;
    localparam logic [BYTE_W-1:0]  IRIS_OPEN_C1 = 8'h02;
    localparam logic [BYTE_W-1:0]  IRIS_CLOSE_C1 = 8'h04;
    localparam logic [BYTE_W-1:0]  AUTOSCAN_C1  = 8'h10;
    localparam logic [BYTE_W-1:0]  PAN_POS_CODE  = 8'h4B;
    localparam logic [BYTE_W-1:0]  TILT_POS_CODE = 8'h4D;
    localparam logic [BYTE_W-1:0]  ZOOM_POS_CODE = 8'h4F;
    localparam logic [VALUE_W-1:0] PAN_TILT_MAX = 16'd35999;
    localparam logic [VALUE_W-1:0] ZOOM_MIN     = 16'd2849;

    // command byte 2 bit masks
    localparam logic [BYTE_W-1:0] C2_RIGHT = 8'h02;
    localparam logic [BYTE_W-1:0] C2_LEFT  = 8'h04;
    localparam logic [BYTE_W-1:0] C2_UP    = 8'h08;
    localparam logic [BYTE_W-1:0] C2_DOWN  = 8'h10;
    localparam logic [BYTE_W-1:0] C2_TELE  = 8'h20;
    localparam logic [BYTE_W-1:0] C2_WIDE  = 8'h40;
    localparam logic [BYTE_W-1:0] C2_FAR   = 8'h80;
    // command byte 1 bit masks
    localparam logic [BYTE_W-1:0] C1_NEAR  = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_RAW        = 5'd0,
        CMD_CAM_ON     = 5'd1,
        CMD_CAM_OFF    = 5'd2,
        CMD_MOVE       = 5'd3,
        CMD_FOCUS_FAR  = 5'd4,
        CMD_FOCUS_NEAR = 5'd5,
        CMD_FOCUS_STOP = 5'd6,
        CMD_IRIS_OPEN  = 5'd7,
        CMD_IRIS_CLOSE = 5'd8,
        CMD_ZOOM_WIDE  = 5'd9,
        CMD_ZOOM_TELE  = 5'd10,
        CMD_ZOOM_STOP  = 5'd11,
        CMD_AUTOSCAN   = 5'd12,
        CMD_EXT        = 5'd13,
        CMD_PAN_POS    = 5'd14,
        CMD_TILT_POS   = 5'd15,
        CMD_ZOOM_POS   = 5'd16
    } cmd_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    // one registered command request
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  address;
        logic [BYTE_W-1:0]  raw_control_one;
        logic [BYTE_W-1:0]  type_code;
        logic [BYTE_W-1:0]  data_high;
        logic [VALUE_W-1:0] value;
        logic [DIR_W-1:0]   direction;
        logic               clear_first;
    } req_t;

    // the four body bytes kept between frames
    typedef struct packed {
        logic [BYTE_W-1:0] control_one;
        logic [BYTE_W-1:0] control_two;
        logic [BYTE_W-1:0] data_one;
        logic [BYTE_W-1:0] data_two;
    } body_t;

    // a complete frame minus the sync byte
    typedef struct packed {
        logic [BYTE_W-1:0] address;
        body_t             body;
        logic [BYTE_W-1:0] checksum;
    } frame_t;

endpackage

>>> rtl/ptz_command_frame_builder_top.sv
// A request goes through the input register, the pending frame slot, then the
// output serializer; its frame leaves as 7 bytes, one per cycle unless out_stall.
// New requests are taken while a frame is sent, until the input register and
// pending slot are full; a pending frame starts in the cycle after a checksum byte.
// Reset (rst_n, async low): pipeline empty, kept body bytes cleared to zero.
// Unknown command codes never wait for the pending slot and send nothing.
module ptz_command_frame_builder_top
    import ptzfb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [BYTE_W-1:0]   address,
    input  logic [BYTE_W-1:0]   raw_control_one,
    input  logic [BYTE_W-1:0]   type_code,
    input  logic [BYTE_W-1:0]   data_high,
    input  logic [VALUE_W-1:0]  value,
    input  logic [DIR_W-1:0]    direction,
    input  logic                clear_first,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BYTE_W-1:0]   frame_byte,
    output logic                last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    req_t              req_reg;
    logic              req_valid_reg;
    body_t             body_reg;
    body_t             body_next;
    frame_t            calc_frame;
    logic              calc_known;
    frame_t            pend_reg;
    logic              pend_valid_reg;
    logic [FRAME_LEN*BYTE_W-1:0] shift_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              busy_reg;
    logic              in_fire;
    logic              out_fire;
    logic              frame_done;
    logic              load;
    logic              advance;
    logic              calc_fire;

    // handshake and pipeline movement
    assign in_fire    = in_valid && !in_stall;
    assign out_fire   = busy_reg && !out_stall;
    assign frame_done = out_fire && (idx_reg == LAST_IDX);
    assign load       = pend_valid_reg && (!busy_reg || frame_done);
    assign advance    = req_valid_reg && (!pend_valid_reg || load || !calc_known);
    assign calc_fire  = advance && calc_known;
    assign in_stall   = req_valid_reg && !advance;

    ptzfb_body_calc u_calc (
        .req       (req_reg),
        .body      (body_reg),
        .body_next (body_next),
        .frame     (calc_frame),
        .known     (calc_known)
    );

    // input request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= '{cmd, address, raw_control_one, type_code, data_high,
                         value, direction, clear_first};
        end
    end

    // kept body bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_reg <= '0;
        end
        else if (calc_fire)
        begin
            body_reg <= body_next;
        end
    end

    // pending frame slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (calc_fire)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_fire)
        begin
            pend_reg <= calc_frame;
        end
    end

    // output serializer, sync byte first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (frame_done)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (out_fire)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= {FRAME_SYNC, pend_reg};
        end
        else if (out_fire)
        begin
            shift_reg <= {shift_reg[(FRAME_LEN-1)*BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
    end

    assign out_valid  = busy_reg;
    assign frame_byte = shift_reg[FRAME_LEN*BYTE_W-1 -: BYTE_W];
    assign last       = busy_reg && (idx_reg == LAST_IDX);

`ifndef ASSERT_OFF
    // every frame opens with the sync byte
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (idx_reg == '0) |-> frame_byte == FRAME_SYNC)
        else $error("frame does not start with sync byte");

    // bytes of one frame follow without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !last |=> out_valid)
        else $error("gap inside a frame");

    // kept body only changes when a known command is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !calc_fire |=> $stable(body_reg))
        else $error("body changed without a command");

    // a pending frame is never overwritten before it is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !load |-> !calc_fire)
        else $error("pending frame overwritten");
`endif

endmodule

>>> rtl/ptzfb_body_calc.sv
// Next body bytes and checksum for one command request.
module ptzfb_body_calc
    import ptzfb_pkg::*;
(
    input  req_t   req,
    input  body_t  body,
    output body_t  body_next,
    output frame_t frame,
    output logic   known
);

    // clear command byte 2 when it holds stray or conflicting bits
    function automatic logic [BYTE_W-1:0] sanitize(input logic [BYTE_W-1:0] c2);
        logic lr;
        logic ud;
        lr = (c2 & (C2_LEFT | C2_RIGHT)) == (C2_LEFT | C2_RIGHT);
        ud = (c2 & (C2_UP | C2_DOWN)) == (C2_UP | C2_DOWN);
        return (((c2 & STRAY_MASK) != '0) || lr || ud) ? '0 : c2;
    endfunction

    logic [BYTE_W-1:0]  spd;
    logic [VALUE_W-1:0] pt_pos;
    logic [VALUE_W-1:0] zoom_pos;
    logic [BYTE_W-1:0]  c2_san;
    body_t              mv;

    assign spd      = req.value[BYTE_W-1:0];
    assign pt_pos   = (req.value > PAN_TILT_MAX) ? PAN_TILT_MAX : req.value;
    assign zoom_pos = (req.value < ZOOM_MIN) ? ZOOM_MIN : req.value;
    assign c2_san   = sanitize(body.control_two);

    // move: clear command byte 1, optional clear, sanitize, then the direction
    always_comb
    begin
        mv             = body;
        mv.control_one = '0;
        if (req.clear_first)
        begin
            mv.control_two = '0;
            mv.data_one    = '0;
            mv.data_two    = '0;
        end
        mv.control_two = sanitize(mv.control_two);
        case (req.direction)
            DIR_STOP:
            begin
                mv.control_two = '0;
                mv.data_one    = '0;
                mv.data_two    = '0;
            end
            DIR_UP:
            begin
                mv.control_two = (mv.control_two | C2_UP) & ~C2_DOWN;
                mv.data_two    = spd;
            end
            DIR_DOWN:
            begin
                mv.control_two = (mv.control_two | C2_DOWN) & ~C2_UP;
                mv.data_two    = spd;
            end
            DIR_LEFT:
            begin
                mv.control_two = (mv.control_two | C2_LEFT) & ~C2_RIGHT;
                mv.data_one    = spd;
            end
            DIR_RIGHT:
            begin
                mv.control_two = (mv.control_two | C2_RIGHT) & ~C2_LEFT;
                mv.data_one    = spd;
            end
            default:
            begin
                // out-of-range direction: clearing and sanitizing only
            end
        endcase
    end

    // per-command body update
    always_comb
    begin
        body_next = body;
        known     = 1'b1;
        unique case (req.cmd)
            CMD_RAW:     body_next = '{req.raw_control_one, req.type_code, req.data_high, spd};
            CMD_CAM_ON:  body_next = '{CAM_ON_C1, 8'h00, 8'h00, 8'h00};
            CMD_CAM_OFF: body_next = '{CAM_OFF_C1, 8'h00, 8'h00, 8'h00};
            CMD_MOVE:    body_next = mv;
            CMD_FOCUS_FAR:
            begin
                body_next.control_one = body.control_one & ~C1_NEAR;
                body_next.control_two = c2_san | C2_FAR;
            end
            CMD_FOCUS_NEAR:
            begin
                body_next.control_one = body.control_one | C1_NEAR;
                body_next.control_two = c2_san & ~C2_FAR;
            end
            CMD_FOCUS_STOP:
            begin
                body_next.control_one = body.control_one & ~C1_NEAR;
                body_next.control_two = body.control_two & ~C2_FAR;
            end
            CMD_IRIS_OPEN:  body_next.control_one = IRIS_OPEN_C1;
            CMD_IRIS_CLOSE: body_next.control_one = IRIS_CLOSE_C1;
            CMD_ZOOM_WIDE:  body_next.control_two = (c2_san | C2_WIDE) & ~C2_TELE;
            CMD_ZOOM_TELE:  body_next.control_two = (c2_san | C2_TELE) & ~C2_WIDE;
            CMD_ZOOM_STOP:  body_next.control_two = body.control_two & ~(C2_WIDE | C2_TELE);
            CMD_AUTOSCAN:
            begin
                body_next.control_one = AUTOSCAN_C1;
                body_next.control_two = '0;
            end
            CMD_EXT:      body_next = '{8'h00, req.type_code, req.data_high, spd};
            CMD_PAN_POS:  body_next = '{8'h00, PAN_POS_CODE, pt_pos[15:8], pt_pos[7:0]};
            CMD_TILT_POS: body_next = '{8'h00, TILT_POS_CODE, pt_pos[15:8], pt_pos[7:0]};
            CMD_ZOOM_POS: body_next = '{8'h00, ZOOM_POS_CODE, zoom_pos[15:8], zoom_pos[7:0]};
            default:      known = 1'b0;
        endcase
    end

    // frame contents, checksum wraps modulo 256
    always_comb
    begin
        frame.address  = req.address;
        frame.body     = body_next;
        frame.checksum = req.address + body_next.control_one + body_next.control_two
                       + body_next.data_one + body_next.data_two;
    end

endmodule

>>> tb/ptz_frame_checker.sv
// Checker for the PTZ frame builder: predicts each frame from accepted requests and scores output bytes.
`timescale 1ns / 1ps
module ptz_frame_checker
    import ptzfb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [BYTE_W-1:0]   address,
    input  logic [BYTE_W-1:0]   raw_control_one,
    input  logic [BYTE_W-1:0]   type_code,
    input  logic [BYTE_W-1:0]   data_high,
    input  logic [VALUE_W-1:0]  value,
    input  logic [DIR_W-1:0]    direction,
    input  logic                clear_first,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [BYTE_W-1:0]   frame_byte,
    input  logic                last,
    output int                  mismatches,
    output int                  bytes_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              last_flag;
    } frame_byte_t;

    // body bytes carried from one frame to the next
    body_t       body;
    // frame bytes still owed by the block, oldest first
    frame_byte_t frame_bytes_due[$];
    int          fail_tally;

    // drop command byte 2 when it carries stray bits or opposing directions
    function automatic logic [BYTE_W-1:0] scrub_control_two(input logic [BYTE_W-1:0] c2);
        logic lr;
        logic ud;
        lr = (c2 & (C2_LEFT | C2_RIGHT)) == (C2_LEFT | C2_RIGHT);
        ud = (c2 & (C2_UP | C2_DOWN)) == (C2_UP | C2_DOWN);
        if ((c2 & STRAY_MASK) != '0 || lr || ud)
            return '0;
        return c2;
    endfunction

    // update the kept body for one request; returns 1 when a frame goes out
    function automatic bit apply_request(input req_t r);
        logic [BYTE_W-1:0]  spd;
        logic [VALUE_W-1:0] pos;
        spd = r.value[BYTE_W-1:0];
        pos = r.value;
        case (r.cmd)
            CMD_RAW:      body = {r.raw_control_one, r.type_code, r.data_high, spd};
            CMD_CAM_ON:   body = {CAM_ON_C1, 8'h00, 8'h00, 8'h00};
            CMD_CAM_OFF:  body = {CAM_OFF_C1, 8'h00, 8'h00, 8'h00};
            CMD_MOVE:
            begin
                body.control_one = '0;
                if (r.clear_first)
                begin
                    body.control_two = '0;
                    body.data_one    = '0;
                    body.data_two    = '0;
                end
                body.control_two = scrub_control_two(body.control_two);
                case (r.direction)
                    DIR_STOP:
                    begin
                        body.control_two = '0;
                        body.data_one    = '0;
                        body.data_two    = '0;
                    end
                    DIR_UP:
                    begin
                        body.control_two = (body.control_two | C2_UP) & ~C2_DOWN;
                        body.data_two    = spd;
                    end
                    DIR_DOWN:
                    begin
                        body.control_two = (body.control_two | C2_DOWN) & ~C2_UP;
                        body.data_two    = spd;
                    end
                    DIR_LEFT:
                    begin
                        body.control_two = (body.control_two | C2_LEFT) & ~C2_RIGHT;
                        body.data_one    = spd;
                    end
                    DIR_RIGHT:
                    begin
                        body.control_two = (body.control_two | C2_RIGHT) & ~C2_LEFT;
                        body.data_one    = spd;
                    end
                    default: ;  // bad direction: only clearing and scrubbing apply
                endcase
            end
            CMD_FOCUS_FAR:
            begin
                body.control_two = scrub_control_two(body.control_two);
                body.control_one = body.control_one & ~C1_NEAR;
                body.control_two = body.control_two | C2_FAR;
            end
            CMD_FOCUS_NEAR:
            begin
                body.control_two = scrub_control_two(body.control_two);
                body.control_one = body.control_one | C1_NEAR;
                body.control_two = body.control_two & ~C2_FAR;
            end
            CMD_FOCUS_STOP:
            begin
                body.control_one = body.control_one & ~C1_NEAR;
                body.control_two = body.control_two & ~C2_FAR;
            end
            CMD_IRIS_OPEN:  body.control_one = IRIS_OPEN_C1;
            CMD_IRIS_CLOSE: body.control_one = IRIS_CLOSE_C1;
            CMD_ZOOM_WIDE:
            begin
                body.control_two = scrub_control_two(body.control_two);
                body.control_two = (body.control_two | C2_WIDE) & ~C2_TELE;
            end
            CMD_ZOOM_TELE:
            begin
                body.control_two = scrub_control_two(body.control_two);
                body.control_two = (body.control_two | C2_TELE) & ~C2_WIDE;
            end
            CMD_ZOOM_STOP:  body.control_two = body.control_two & ~(C2_TELE | C2_WIDE);
            CMD_AUTOSCAN:
            begin
                body.control_one = AUTOSCAN_C1;
                body.control_two = '0;
            end
            CMD_EXT:        body = {8'h00, r.type_code, r.data_high, spd};
            CMD_PAN_POS, CMD_TILT_POS:
            begin
                if (pos > PAN_TILT_MAX)
                    pos = PAN_TILT_MAX;
                body = {8'h00, (r.cmd == CMD_PAN_POS) ? PAN_POS_CODE : TILT_POS_CODE,
                        pos[15:8], pos[7:0]};
            end
            CMD_ZOOM_POS:
            begin
                if (pos < ZOOM_MIN)
                    pos = ZOOM_MIN;
                body = {8'h00, ZOOM_POS_CODE, pos[15:8], pos[7:0]};
            end
            default: return 1'b0;  // unused codes: no frame, body untouched
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_byte_t       due;
        req_t              req;
        logic [BYTE_W-1:0] fb [FRAME_LEN];
        if (!rst_n)
        begin
            body = '0;
            frame_bytes_due.delete();
            fail_tally = 0;
            mismatches    <= 0;
            bytes_pending <= 0;
        end
        else
        begin
            // score a byte taken from the block
            if (out_valid && !out_stall)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= 10)
                        $display("%0t: unexpected byte %02h last %0b", $realtime, frame_byte,
                                 last);
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (frame_byte !== due.byte_val || last !== due.last_flag)
                    begin
                        fail_tally++;
                        if (fail_tally <= 10)
                            $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                                     $realtime, due.byte_val, due.last_flag, frame_byte, last);
                    end
                end
            end
            // predict the frame of a newly taken request
            if (in_valid && !in_stall)
            begin
                req = {cmd, address, raw_control_one, type_code, data_high, value, direction,
                       clear_first};
                if (apply_request(req))
                begin
                    fb[0] = FRAME_SYNC;
                    fb[1] = address;
                    fb[2] = body.control_one;
                    fb[3] = body.control_two;
                    fb[4] = body.data_one;
                    fb[5] = body.data_two;
                    fb[6] = address + body.control_one + body.control_two + body.data_one
                            + body.data_two;
                    for (int k = 0; k < FRAME_LEN; k++)
                        frame_bytes_due.push_back({fb[k], k == FRAME_LEN - 1});
                end
            end
            mismatches    <= fail_tally;
            bytes_pending <= frame_bytes_due.size();
        end
    end

endmodule

>>> tb/tb_ptz_command_frame_builder_top.sv
// Testbench top for the PTZ command frame builder: request stimulus, output stalls, verdict.
`timescale 1ns / 1ps
module tb_ptz_command_frame_builder_top
    import ptzfb_pkg::*;
();

    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_REQUESTS = 500;
    localparam int DRAIN_CYCLES    = 20;
    // command and direction codes the block does not define
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 5'd17;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 5'd31;
    localparam logic [DIR_W-1:0] DIR_FIRST_UNUSED = 3'd5;
    localparam logic [DIR_W-1:0] DIR_LAST_UNUSED  = 3'd7;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               in_valid        = 1'b0;
    logic [CMD_W-1:0]   cmd             = '0;
    logic [BYTE_W-1:0]  address         = '0;
    logic [BYTE_W-1:0]  raw_control_one = '0;
    logic [BYTE_W-1:0]  type_code       = '0;
    logic [BYTE_W-1:0]  data_high       = '0;
    logic [VALUE_W-1:0] value           = '0;
    logic [DIR_W-1:0]   direction       = '0;
    logic               clear_first     = 1'b0;
    logic               out_stall       = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [BYTE_W-1:0]  frame_byte;
    logic               last;

    int   mismatches;
    int   bytes_pending;
    int   cycle_count  = 0;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    logic hold_active  = 1'b0;
    event hold_go;

    ptz_command_frame_builder_top dut (.*);
    ptz_frame_checker checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ptz_command_frame_builder_top regression: fail");
            $finish;
        end
    end

    // byte side: random stalls, or a solid hold-off while hold_active
    always @(posedge clk)
        out_stall <= hold_active || ($urandom_range(0, 99) < rcv_idle_pct);

    // long hold-off so the block backs up into its request port
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // offer one request, with random idle cycles first, and wait until taken
    task automatic send_request(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] a,
                                input logic [BYTE_W-1:0] r1, input logic [BYTE_W-1:0] tc,
                                input logic [BYTE_W-1:0] dh, input logic [VALUE_W-1:0] v,
                                input logic [DIR_W-1:0] d, input logic cf);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= c;
        address         <= a;
        raw_control_one <= r1;
        type_code       <= tc;
        data_high       <= dh;
        value           <= v;
        direction       <= d;
        clear_first     <= cf;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // random request; mostly commands that edit the kept body bits
    task automatic send_random_request(output bit framed);
        logic [CMD_W-1:0]   c;
        logic [VALUE_W-1:0] v;
        logic [DIR_W-1:0]   d;
        logic [BYTE_W-1:0]  tc;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            c = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        else if (pick < 50)
        begin
            case ($urandom_range(0, 8))
                0:       c = CMD_FOCUS_FAR;
                1:       c = CMD_FOCUS_NEAR;
                2:       c = CMD_FOCUS_STOP;
                3:       c = CMD_ZOOM_WIDE;
                4:       c = CMD_ZOOM_TELE;
                5:       c = CMD_ZOOM_STOP;
                default: c = CMD_MOVE;
            endcase
        end
        else
            c = CMD_W'($urandom_range(CMD_RAW, CMD_ZOOM_POS));
        // positions near the limits now and then
        case ($urandom_range(0, 9))
            0:       v = PAN_TILT_MAX + VALUE_W'($urandom_range(0, 2)) - 16'd1;
            1:       v = ZOOM_MIN + VALUE_W'($urandom_range(0, 2)) - 16'd1;
            2:       v = '1;
            3:       v = '0;
            default: v = VALUE_W'($urandom);
        endcase
        if ($urandom_range(0, 9) == 0)
            d = DIR_W'($urandom_range(DIR_FIRST_UNUSED, DIR_LAST_UNUSED));
        else
            d = DIR_W'($urandom_range(DIR_STOP, DIR_RIGHT));
        // half the raw codes carry no stray bits, so the kept bits survive
        tc = BYTE_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            tc = tc & ~STRAY_MASK;
        send_request(c, BYTE_W'($urandom), BYTE_W'($urandom), tc, BYTE_W'($urandom), v, d,
                     1'($urandom));
        framed = (c <= CMD_ZOOM_POS);
    endtask

    initial
    begin
        int sent;
        bit framed;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests: extremes, every command, scrubbing and limits
        snd_idle_pct = 11;
        rcv_idle_pct = 71;
        send_request(CMD_RAW, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_RAW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, DIR_LAST_UNUSED, 1'b1);
        // stray bits cleared before focus far
        send_request(CMD_FOCUS_FAR, 8'h01, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        // left and right together cleared before zoom tele
        send_request(CMD_RAW, 8'h02, 8'h00, C2_LEFT | C2_RIGHT, 8'h11, 16'h0022, DIR_STOP, 1'b0);
        send_request(CMD_ZOOM_TELE, 8'h03, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        // up and down together cleared before a move
        send_request(CMD_RAW, 8'h04, 8'h00, C2_UP | C2_DOWN, 8'h33, 16'h0044, DIR_STOP, 1'b0);
        send_request(CMD_MOVE, 8'h05, 8'h00, 8'h00, 8'h00, 16'h00FF, DIR_UP, 1'b0);
        send_request(CMD_MOVE, 8'h06, 8'h00, 8'h00, 8'h00, 16'h013F, DIR_LEFT, 1'b0);
        send_request(CMD_MOVE, 8'h07, 8'h00, 8'h00, 8'h00, 16'h0001, DIR_RIGHT, 1'b1);
        send_request(CMD_MOVE, 8'h08, 8'h00, 8'h00, 8'h00, 16'h0080, DIR_DOWN, 1'b0);
        send_request(CMD_MOVE, 8'h09, 8'h00, 8'h00, 8'h00, 16'h0055, DIR_STOP, 1'b0);
        send_request(CMD_MOVE, 8'h0A, 8'h00, 8'h00, 8'h00, 16'h0066, DIR_LAST_UNUSED, 1'b1);
        send_request(CMD_MOVE, 8'h0B, 8'h00, 8'h00, 8'h00, 16'h0077, DIR_FIRST_UNUSED, 1'b0);
        send_request(CMD_FOCUS_NEAR, 8'h0C, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_FOCUS_STOP, 8'h0D, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_ZOOM_WIDE, 8'h0E, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_ZOOM_STOP, 8'h0F, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_IRIS_OPEN, 8'h10, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_IRIS_CLOSE, 8'h20, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_CAM_ON, 8'h40, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_CAM_OFF, 8'h80, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_AUTOSCAN, 8'hFE, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_EXT, 8'h7F, 8'hFF, 8'h07, 8'h01, 16'hA522, DIR_STOP, 1'b0);
        // pan and tilt saturate, zoom is raised to its floor
        send_request(CMD_PAN_POS, 8'h21, 8'h00, 8'h00, 8'h00, PAN_TILT_MAX + 16'd1, DIR_STOP, 1'b0);
        send_request(CMD_PAN_POS, 8'h22, 8'h00, 8'h00, 8'h00, PAN_TILT_MAX, DIR_STOP, 1'b0);
        send_request(CMD_TILT_POS, 8'h23, 8'h00, 8'h00, 8'h00, 16'hFFFF, DIR_STOP, 1'b0);
        send_request(CMD_ZOOM_POS, 8'h24, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_ZOOM_POS, 8'h25, 8'h00, 8'h00, 8'h00, 16'hFFFF, DIR_STOP, 1'b0);
        // unused codes send nothing
        send_request(CMD_FIRST_UNUSED, 8'h26, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);
        send_request(CMD_LAST_UNUSED, 8'h27, 8'h00, 8'h00, 8'h00, 16'h0000, DIR_STOP, 1'b0);

        // random requests: slow receiver, then slow sender, then full rate with a long output hold
        while (sent < RANDOM_REQUESTS / 3)
        begin
            send_random_request(framed);
            if (framed)
                sent++;
        end
        snd_idle_pct = 71;
        rcv_idle_pct = 11;
        while (sent < 2 * RANDOM_REQUESTS / 3)
        begin
            send_random_request(framed);
            if (framed)
                sent++;
        end
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        -> hold_go;
        while (sent < RANDOM_REQUESTS)
        begin
            send_random_request(framed);
            if (framed)
                sent++;
        end
        in_valid <= 1'b0;

        // drain, then give the verdict
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && bytes_pending == 0)
            $display("ptz_command_frame_builder_top regression: pass");
        else
            $display("ptz_command_frame_builder_top regression: fail");
        $finish;
    end

endmodule
